FILE: rtl/wsf_pkg.sv
// Shared types and constants for the first-difference Whittaker smoother.
// Used by controller, datapath, divider and top level; no dependencies.
package wsf_pkg;
   localparam int unsigned LAMBDA_MIN = 32'd131072;
   localparam int unsigned ONE_Q16    = 32'd65536;
   localparam logic signed [47:0] MAX48 = 48'sh7FFF_FFFF_FFFF;
   localparam logic signed [47:0] MIN48 = 48'sh8000_0000_0000;

   typedef enum logic [3:0] {
      ST_IDLE, ST_FWD_RD, ST_FWD_MUL, ST_FWD_NUM, ST_DIV_D, ST_DIV_R, ST_FWD_WR,
      ST_BK_RD, ST_BK_MUL, ST_BK_WR, ST_OUT_RD, ST_OUT_SEND
   } state_type;

   typedef struct packed {
      logic load;      // capture request, read previous entries
      logic mul;       // form products
      logic num;       // form pivot and numerator
      logic div_d;     // start quotient d'
      logic div_r;     // start quotient r
      logic fwd_wr;    // write forward entry
      logic bk_rd;     // read entries for back-substitution
      logic bk_mul;
      logic bk_wr;
      logic out_rd;    // read entry for output
      logic out_load;  // load output register
   } cmd_type;

   typedef struct packed {
      logic div_busy;
      logic last;
      logic out_full;
   } sts_type;
endpackage

FILE: rtl/whittaker_smoother_first_order.sv
// Top level of the first-difference Whittaker smoother.
// Joins wsf_ctrl and wsf_dp; uses wsf_pkg.
//
// Usage: write lambda (unsigned Q16.16) on csr_we/csr_wdata while idle;
// values under 2.0 act as 2.0. Send samples on req_*, tdata = sample,
// tlast = end of series. Each request runs the 80-step bit-serial divider
// twice (quotient d' and ratio r) before the next ready. A request that
// ends the series (tlast, or the one that fills the store) then runs
// back-substitution, reading, multiplying and writing back each earlier
// point in turn, and emits the smoothed series on rsp_* in index order,
// reading each result and then loading it into the output register.
// rsp_tdata holds smoothed, point_index, final_point; rsp_tlast marks the
// final point.
// A stalled receiver holds the output register and the sequencer waits.
// Reset clears the sequencer, the point count and the output valid, and
// sets lambda to 2.0.
module whittaker_smoother_first_order #(
   parameter int MAX_POINTS = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [31:0] csr_wdata,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] sample
   input  logic        req_tlast,   // series_end
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [31:0] smoothed, [37:32] point_index, [38] final_point
   output logic        rsp_tlast
);
   import wsf_pkg::*;
   cmd_type cmd;
   sts_type sts;
   logic out_done, bk_done;

   wsf_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_tvalid(req_tvalid), .req_tready(req_tready),
      .out_done(out_done), .bk_done(bk_done), .sts(sts), .cmd(cmd)
   );

   wsf_dp #(.MAX_POINTS(MAX_POINTS)) u_dp (
      .clock(clock), .reset(reset), .csr_wdata(csr_wdata), .csr_we(csr_we),
      .req_sample(req_tdata), .req_last(req_tlast), .cmd(cmd), .sts(sts),
      .out_done(out_done), .bk_done(bk_done), .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata), .rsp_tlast(rsp_tlast)
   );
endmodule

FILE: rtl/wsf_div.sv
// Restoring divider, one quotient bit per cycle: quotient of an 80-bit
// dividend by a 34-bit divisor. Uses wsf_pkg.
module wsf_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [79:0] dividend,
   input  logic [33:0] divisor,
   output logic        busy,
   output logic [79:0] quotient
);
   import wsf_pkg::*;
   logic [79:0] quot_ff, quot_in;
   logic [34:0] rem_ff, rem_in;
   logic [33:0] dvs_ff, dvs_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic [34:0] trial;
   logic [35:0] diff;

   always_comb begin
      quot_in = quot_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      trial   = {rem_ff[33:0], quot_ff[79]};
      diff    = {1'b0, trial} - {2'b0, dvs_ff};
      if (start) begin
         quot_in = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
         cnt_in  = 7'd80;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!diff[35]) begin
            rem_in  = diff[34:0];
            quot_in = {quot_ff[78:0], 1'b1};
         end else begin
            rem_in  = trial;
            quot_in = {quot_ff[78:0], 1'b0};
         end
         cnt_in = cnt_ff - 7'd1;
         if (cnt_ff == 7'd1) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      dvs_ff  <= dvs_in;
      cnt_ff  <= cnt_in;
      if (reset) busy_ff <= 1'b0;
      else       busy_ff <= busy_in;
   end

   assign busy     = busy_ff;
   assign quotient = quot_ff;
endmodule

FILE: rtl/wsf_ctrl.sv
// Sequencer for the smoother: forward sweep per request, back-substitution
// and ordered emission at series end. Uses wsf_pkg.
module wsf_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic              out_done,
   input  logic              bk_done,
   input  wsf_pkg::sts_type  sts,
   output wsf_pkg::cmd_type  cmd
);
   import wsf_pkg::*;
   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ST_FWD_MUL;
            end
         end
         ST_FWD_RD:  state_in = ST_FWD_MUL;
         ST_FWD_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_FWD_NUM;
         end
         ST_FWD_NUM: begin
            cmd.num  = 1'b1;
            state_in = ST_DIV_D;
         end
         ST_DIV_D: begin
            cmd.div_d = 1'b1;
            state_in  = ST_DIV_R;
         end
         ST_DIV_R: begin
            if (!sts.div_busy) begin
               cmd.div_r = 1'b1;
               state_in  = ST_FWD_WR;
            end
         end
         ST_FWD_WR: begin
            if (!sts.div_busy) begin
               cmd.fwd_wr = 1'b1;
               state_in   = sts.last ? ST_BK_RD : ST_IDLE;
            end
         end
         ST_BK_RD: begin
            if (bk_done) state_in = ST_OUT_RD;
            else begin
               cmd.bk_rd = 1'b1;
               state_in  = ST_BK_MUL;
            end
         end
         ST_BK_MUL: begin
            cmd.bk_mul = 1'b1;
            state_in   = ST_BK_WR;
         end
         ST_BK_WR: begin
            cmd.bk_wr = 1'b1;
            state_in  = ST_BK_RD;
         end
         ST_OUT_RD: begin
            cmd.out_rd = 1'b1;
            state_in   = ST_OUT_SEND;
         end
         ST_OUT_SEND: begin
            if (!sts.out_full) begin
               cmd.out_load = 1'b1;
               state_in     = out_done ? ST_IDLE : ST_OUT_RD;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end
endmodule

FILE: rtl/wsf_dp.sv
// Datapath: stores, multipliers, divider and output register of the
// smoother. Uses wsf_pkg and wsf_div.
module wsf_dp #(
   parameter int MAX_POINTS = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  logic [31:0]      csr_wdata,
   input  logic             csr_we,
   input  logic [31:0]      req_sample,
   input  logic             req_last,
   input  wsf_pkg::cmd_type cmd,
   output wsf_pkg::sts_type sts,
   output logic             out_done,
   output logic             bk_done,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [39:0]      rsp_tdata,
   output logic             rsp_tlast
);
   import wsf_pkg::*;
   localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;

   logic signed [47:0] fwd_mem [MAX_POINTS];
   logic [31:0]        rat_mem [MAX_POINTS];

   logic [31:0]        lam_ff;
   logic [6:0]         cnt_ff;
   logic [AW-1:0]      idx_ff;
   logic               last_ff;
   logic signed [32:0] y_ff;
   logic signed [47:0] dprev_ff;
   logic [31:0]        rprev_ff;
   logic [63:0]        prod_r_ff;
   logic signed [64:0] phi_ff;
   logic [47:0]        plo_ff;
   logic [33:0]        m_ff;
   logic               neg_ff;
   logic [47:0]        amag_ff;
   logic [AW-1:0]      bk_ff;
   logic signed [47:0] znext_ff;
   logic signed [47:0] dcur_ff;
   logic [31:0]        rcur_ff;
   logic [AW-1:0]      oi_ff;
   logic signed [47:0] oval_ff;
   logic               ov_ff;
   logic [39:0]        od_ff;
   logic               ol_ff;

   logic [31:0] lam_eff;
   assign lam_eff = (lam_ff < LAMBDA_MIN) ? LAMBDA_MIN : lam_ff;

   logic        dstart;
   logic [79:0] dvd;
   logic        dbusy;
   logic [79:0] dq;
   logic [47:0] q_sat;
   logic        pend_d;
   logic signed [47:0] dres_ff;

   wsf_div u_div (
      .clock(clock), .reset(reset), .start(dstart), .dividend(dvd),
      .divisor(m_ff), .busy(dbusy), .quotient(dq)
   );

   assign dstart = cmd.div_d | cmd.div_r;
   assign dvd    = cmd.div_d ? {amag_ff, 32'd0} : {16'd0, lam_eff, 32'd0};
   assign q_sat  = (|dq[79:47]) ? MAX48 : dq[47:0];

   // floor(k*d/2^32) from the split products k*d[47:16] and k*d[15:0]
   logic signed [64:0] msum;
   logic signed [63:0] mshift_w;
   logic signed [64:0] num_w;
   logic [65:0]        bsum;
   logic [63:0]        amag_w;
   logic signed [64:0] zsum;
   logic signed [47:0] zsat;
   logic signed [48:0] rnd;
   logic signed [32:0] rq;
   logic [31:0]        oq;

   always_comb begin
      msum     = phi_ff + $signed({33'd0, plo_ff[47:16]});
      mshift_w = 64'(msum >>> 16);
      num_w  = 65'(y_ff) + ((idx_ff != '0) ? 65'(mshift_w) : 65'sd0);
      amag_w = num_w[64] ? 64'(-num_w) : 64'(num_w);
      bsum   = 66'(ONE_Q16) + ((idx_ff != '0) ? 66'(lam_eff) : 66'd0)
             + (last_ff ? 66'd0 : 66'(lam_eff)) - 66'(prod_r_ff[63:32]);
      zsum   = 65'(dcur_ff) + 65'(mshift_w);
      if (zsum > 65'(MAX48))      zsat = MAX48;
      else if (zsum < 65'(MIN48)) zsat = MIN48;
      else                        zsat = zsum[47:0];
      rnd = (49'(oval_ff) + 49'sd32768) >>> 16;
      if (rnd > 49'sd2147483647)       oq = 32'h7FFF_FFFF;
      else if (rnd < -49'sd2147483648) oq = 32'h8000_0000;
      else                             oq = rnd[31:0];
      rq = 33'(rnd);
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         idx_ff  <= (cnt_ff >= 7'(MAX_POINTS - 1)) ? AW'(MAX_POINTS - 1) : cnt_ff[AW-1:0];
         last_ff <= req_last || (cnt_ff >= 7'(MAX_POINTS - 1));
         y_ff    <= 33'($signed(req_sample));
         if (cnt_ff != 7'd0) begin
            dprev_ff <= fwd_mem[cnt_ff[AW-1:0] - AW'(1)];
            rprev_ff <= rat_mem[cnt_ff[AW-1:0] - AW'(1)];
         end else begin
            dprev_ff <= '0;
            rprev_ff <= '0;
         end
      end
      if (cmd.mul) begin
         prod_r_ff <= 64'(lam_eff) * 64'(rprev_ff);
         phi_ff    <= $signed({1'b0, lam_eff}) * $signed(dprev_ff[47:16]);
         plo_ff    <= 48'(lam_eff) * 48'(dprev_ff[15:0]);
      end
      if (cmd.num) begin
         m_ff    <= (bsum[33:0] < 34'(ONE_Q16)) ? 34'(ONE_Q16) : bsum[33:0];
         neg_ff  <= num_w[64];
         amag_ff <= (amag_w > 64'(MAX48)) ? MAX48 : amag_w[47:0];
      end
      if (pend_d && !dbusy) dres_ff <= neg_ff ? -$signed(q_sat) : $signed(q_sat);
      if (cmd.fwd_wr) begin
         fwd_mem[idx_ff] <= dres_ff;
         if (!last_ff) rat_mem[idx_ff] <= dq[31:0];
         bk_ff    <= idx_ff;
         znext_ff <= dres_ff;
      end
      if (cmd.bk_rd) begin
         dcur_ff <= fwd_mem[bk_ff - AW'(1)];
         rcur_ff <= rat_mem[bk_ff - AW'(1)];
      end
      if (cmd.bk_mul) begin
         phi_ff <= $signed({1'b0, rcur_ff}) * $signed(znext_ff[47:16]);
         plo_ff <= 48'(rcur_ff) * 48'(znext_ff[15:0]);
      end
      if (cmd.bk_wr) begin
         fwd_mem[bk_ff - AW'(1)] <= zsat;
         znext_ff <= zsat;
         bk_ff    <= bk_ff - AW'(1);
      end
      if (cmd.out_rd) oval_ff <= fwd_mem[oi_ff];
      if (cmd.out_load) begin
         od_ff <= {1'b0, oi_ff == idx_ff, 6'(oi_ff), oq};
         ol_ff <= (oi_ff == idx_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lam_ff <= LAMBDA_MIN;
         cnt_ff <= '0;
         pend_d <= 1'b0;
         ov_ff  <= 1'b0;
         oi_ff  <= '0;
      end else begin
         if (csr_we) lam_ff <= csr_wdata;
         if (cmd.fwd_wr) cnt_ff <= last_ff ? 7'd0 : 7'(idx_ff) + 7'd1;
         if (cmd.div_d) pend_d <= 1'b1;
         else if (pend_d && !dbusy) pend_d <= 1'b0;
         if (cmd.out_load) begin
            ov_ff <= 1'b1;
            oi_ff <= (oi_ff == idx_ff) ? '0 : oi_ff + AW'(1);
         end else if (rsp_tready) ov_ff <= 1'b0;
      end
   end

   assign sts.div_busy = dbusy | pend_d;
   assign sts.last     = last_ff;
   assign sts.out_full = ov_ff & ~rsp_tready;
   assign out_done     = (oi_ff == idx_ff);
   assign bk_done      = (bk_ff == '0);
   assign rsp_tvalid   = ov_ff;
   assign rsp_tdata    = od_ff;
   assign rsp_tlast    = ol_ff;
   logic unused;
   assign unused = ^rq;
endmodule

FILE: rtl/wsf_check.sv
// Port-level checker for the smoother, bound to the top level.
// Depends only on the top level's ports.
module wsf_check (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [39:0] rsp_tdata,
   input logic        rsp_tlast
);
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");
   a_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tlast == rsp_tdata[38])
      else $error("tlast differs from final flag");
   a_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> !req_tready)
      else $error("request taken mid-series output");
   a_pad: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !rsp_tdata[39])
      else $error("pad bit set");
endmodule

bind whittaker_smoother_first_order wsf_check u_check (
   .clock(clock), .reset(reset), .req_tready(req_tready), .rsp_tvalid(rsp_tvalid),
   .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata), .rsp_tlast(rsp_tlast)
);

FILE: tb/tb_whittaker_smoother_first_order.sv
// Self-checking testbench for whittaker_smoother_first_order: streams sample series,
// varies lambda between series and checks every point against a predictor or typed row.
// Depends on rtl/wsf_pkg.sv and rtl/whittaker_smoother_first_order.sv.
module tb_whittaker_smoother_first_order;
   timeunit 1ns;
   timeprecision 1ps;
   import wsf_pkg::*;

   localparam int NPTS = 64;
   localparam int STALL_LIMIT = 3000;
   localparam longint MAX48_L = 64'sh0000_7FFF_FFFF_FFFF;
   localparam longint MIN48_L = -MAX48_L - 1;

   typedef struct {
      logic [31:0] smoothed;
      logic [5:0]  point_index;
      logic        final_point;
   } point_t;

   typedef struct {
      logic [31:0] sample;
      logic        series_end;
      bit          typed;
      logic [31:0] want;
   } dir_row_t;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_we = 1'b0;
   logic [31:0] csr_wdata = '0;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;
   logic        rsp_tlast;

   // typed expectation travelling with the current request
   bit          cur_typed = 1'b0;
   logic [31:0] cur_want = '0;

   whittaker_smoother_first_order #(.MAX_POINTS(NPTS)) dut (
      .clock(clock), .reset(reset),
      .csr_we(csr_we), .csr_wdata(csr_wdata),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tlast(rsp_tlast)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // smoother state mirror
   longint      rhs_mem [NPTS];
   logic [31:0] ratio_mem [NPTS];
   int          held_points = 0;
   logic [31:0] lambda_reg = LAMBDA_MIN;

   point_t pending_points [$];
   point_t fresh_points [$];
   int     errors = 0;
   int     req_count = 0;
   int     rsp_count = 0;
   int     series_count = 0;
   int     lambda_count = 0;
   int     idle_cycles = 0;
   bit     calm = 1'b0;

   function automatic longint sat48(longint v);
      if (v > MAX48_L) return MAX48_L;
      if (v < MIN48_L) return MIN48_L;
      return v;
   endfunction

   // floor(k * d / 2^32)
   function automatic longint scale_down(longint unsigned k, longint d);
      longint hi, lo, a, b;
      hi = d >>> 16;
      lo = d - hi * 65536;
      a = longint'(k) * hi;
      b = longint'(k) * lo;
      return (a + (b >>> 16)) >>> 16;
   endfunction

   // n * 2^32 / m, truncated toward zero, saturated to 48 bits
   function automatic longint quotient48(longint n, longint unsigned m_in);
      bit neg;
      longint unsigned m, a, t, q1, r1, q;
      neg = n < 0;
      m = (m_in < ONE_Q16) ? 64'(ONE_Q16) : m_in;
      a = neg ? longint'(64'd0) - n : n;
      if (a > longint'(MAX48_L)) a = MAX48_L;
      t = a << 16;
      q1 = t / m;
      r1 = t % m;
      q = (q1 << 16) + ((r1 << 16) / m);
      if (q > longint'(MAX48_L)) q = MAX48_L;
      return neg ? -longint'(q) : longint'(q);
   endfunction

   task automatic smooth_sample(input logic signed [31:0] sample, input logic series_end);
      longint unsigned lam, b, m;
      longint y, num, dprev, r;
      logic [31:0] rprev;
      int idx;
      bit last;
      point_t pt;
      lam = (lambda_reg < LAMBDA_MIN) ? 64'(LAMBDA_MIN) : 64'(lambda_reg);
      idx = (held_points >= NPTS) ? NPTS - 1 : held_points;
      y = sample;
      last = series_end || idx == NPTS - 1;
      rprev = '0;
      dprev = 0;
      if (idx > 0) begin
         rprev = ratio_mem[idx - 1];
         dprev = rhs_mem[idx - 1];
      end
      b = ONE_Q16 + (idx > 0 ? lam : 0) + (last ? 0 : lam);
      m = b - ((lam * 64'(rprev)) >> 32);
      num = y + (idx > 0 ? scale_down(lam, dprev) : 0);
      rhs_mem[idx] = quotient48(num, m);
      if (!last) begin
         ratio_mem[idx] = 32'((lam << 32) / m);
         held_points = idx + 1;
      end else begin
         for (int i = idx - 1; i >= 0; i--)
            rhs_mem[i] = sat48(rhs_mem[i] + scale_down(64'(ratio_mem[i]), rhs_mem[i + 1]));
         for (int i = 0; i <= idx; i++) begin
            r = (rhs_mem[i] + 32768) >>> 16;
            if (r > 64'sd2147483647) r = 64'sd2147483647;
            if (r < -64'sd2147483648) r = -64'sd2147483648;
            pt.smoothed = r[31:0];
            pt.point_index = i[5:0];
            pt.final_point = (i == idx);
            fresh_points.push_back(pt);
         end
         held_points = 0;
         series_count++;
      end
   endtask

   always @(posedge clock) begin
      point_t want;
      if (reset) begin
         idle_cycles <= 0;
      end else begin
         if (csr_we) begin
            lambda_reg = csr_wdata;
         end
         if (req_tvalid && req_tready) begin
            fresh_points.delete();
            smooth_sample(req_tdata, req_tlast);
            req_count++;
            if (cur_typed) begin
               fresh_points.delete();
               want.smoothed = cur_want;
               want.point_index = '0;
               want.final_point = 1'b1;
               fresh_points.push_back(want);
            end
            foreach (fresh_points[i]) pending_points.push_back(fresh_points[i]);
         end
         if (rsp_tvalid && rsp_tready) begin
            rsp_count++;
            if (pending_points.size() == 0) begin
               $error("response with nothing expected: %h", rsp_tdata);
               errors++;
            end else begin
               want = pending_points.pop_front();
               if (rsp_tdata[31:0] !== want.smoothed) begin
                  $error("smoothed: expected %h, got %h", want.smoothed, rsp_tdata[31:0]);
                  errors++;
               end
               if (rsp_tdata[37:32] !== want.point_index) begin
                  $error("point_index: expected %0d, got %0d", want.point_index,
                         rsp_tdata[37:32]);
                  errors++;
               end
               if (rsp_tdata[38] !== want.final_point) begin
                  $error("final_point: expected %b, got %b", want.final_point, rsp_tdata[38]);
                  errors++;
               end
               if (rsp_tlast !== want.final_point) begin
                  $error("rsp_tlast: expected %b, got %b", want.final_point, rsp_tlast);
                  errors++;
               end
            end
         end
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
            idle_cycles <= 0;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
      end
   end

   always @(posedge clock) begin
      if (idle_cycles >= STALL_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // receiver: random stall bursts, none once calm
   initial begin
      int run;
      forever begin
         @(negedge clock);
         if (calm) begin
            rsp_tready = 1'b1;
         end else begin
            rsp_tready = $urandom_range(0, 2) != 0;
            run = $urandom_range(1, 8);
            repeat (run - 1) @(negedge clock);
         end
      end
   end

   task automatic send_request(input logic [31:0] sample, input logic series_end,
                               input bit typed, input logic [31:0] want);
      @(negedge clock);
      if (!calm && $urandom_range(0, 3) == 0) begin
         req_tvalid = 1'b0;
         repeat ($urandom_range(1, 8)) @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata = sample;
      req_tlast = series_end;
      cur_typed = typed;
      cur_want = want;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic drain_and_idle();
      @(negedge clock);
      req_tvalid = 1'b0;
      cur_typed = 1'b0;
      while (pending_points.size() != 0) @(negedge clock);
      repeat (20) @(negedge clock);
   endtask

   task automatic write_lambda(input logic [31:0] value);
      drain_and_idle();
      csr_wdata = value;
      csr_we = 1'b1;
      @(negedge clock);
      csr_we = 1'b0;
      lambda_count++;
   endtask

   function automatic logic [31:0] pick_sample(int kind, int pos);
      case (kind)
         0: return $urandom;
         1: return ($urandom_range(0, 1) != 0) ? 32'h7FFF_FFFF : 32'h8000_0000;
         2: return 32'($signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000);
         default: return 32'(pos * 32'h0001_0000) + 32'($urandom_range(0, 32'h0000_FFFF));
      endcase
   endfunction

   task automatic random_series(inout int budget);
      int len, kind;
      bit full_run;
      full_run = $urandom_range(0, 11) == 0;
      if (full_run) len = NPTS;
      else if ($urandom_range(0, 4) == 0) len = $urandom_range(11, 40);
      else len = $urandom_range(1, 10);
      kind = $urandom_range(0, 3);
      for (int i = 0; i < len; i++) begin
         send_request(pick_sample(($urandom_range(0, 7) == 0) ? 1 : kind, i),
                      (i == len - 1) && (!full_run || $urandom_range(0, 1) != 0),
                      1'b0, '0);
         budget--;
      end
   endtask

   dir_row_t dir_rows [20] = '{
      '{32'h0000_0000, 1'b1, 1'b1, 32'h0000_0000},
      '{32'h7FFF_FFFF, 1'b1, 1'b1, 32'h7FFF_FFFF},
      '{32'h8000_0000, 1'b1, 1'b1, 32'h8000_0000},
      '{32'h0001_0000, 1'b1, 1'b1, 32'h0001_0000},
      '{32'hFFFF_FFFF, 1'b1, 1'b1, 32'hFFFF_FFFF},
      '{32'h0001_0000, 1'b0, 1'b0, 32'h0},
      '{32'h0003_0000, 1'b1, 1'b0, 32'h0},
      '{32'h7FFF_FFFF, 1'b0, 1'b0, 32'h0},
      '{32'h8000_0000, 1'b0, 1'b0, 32'h0},
      '{32'h7FFF_FFFF, 1'b1, 1'b0, 32'h0},
      '{32'h0000_0000, 1'b0, 1'b0, 32'h0},
      '{32'hFFFF_0000, 1'b0, 1'b0, 32'h0},
      '{32'h1234_5678, 1'b0, 1'b0, 32'h0},
      '{32'h8000_0000, 1'b1, 1'b0, 32'h0},
      '{32'h8000_0000, 1'b0, 1'b0, 32'h0},
      '{32'h8000_0000, 1'b0, 1'b0, 32'h0},
      '{32'h8000_0000, 1'b1, 1'b0, 32'h0},
      '{32'h0005_0000, 1'b0, 1'b0, 32'h0},
      '{32'h0005_0000, 1'b0, 1'b0, 32'h0},
      '{32'h0005_0000, 1'b1, 1'b0, 32'h0}
   };

   logic [31:0] lambda_plan [8] = '{
      32'h0000_0000, 32'h0000_0001, 32'h0001_FFFF, 32'h0002_0000,
      32'hFFFF_FFFF, 32'h0030_0000, 32'h0000_0000, 32'h0000_0000
   };

   initial begin
      int budget;
      lambda_plan[6] = $urandom;
      lambda_plan[7] = $urandom_range(32'h0002_0000, 32'h0100_0000);
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (dir_rows[i])
         send_request(dir_rows[i].sample, dir_rows[i].series_end, dir_rows[i].typed,
                      dir_rows[i].want);

      foreach (lambda_plan[p]) begin
         write_lambda(lambda_plan[p]);
         if (p == 7) calm = 1'b1;
         budget = 30;
         while (budget > 0) random_series(budget);
      end
      drain_and_idle();

      $display("covered %0d requests in %0d series, %0d points checked", req_count,
               series_count, rsp_count);
      $display("lambda settings used: %0d including floor and full-scale", lambda_count + 1);
      if (errors == 0 && pending_points.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end
endmodule

FILE: filelist.f
rtl/wsf_pkg.sv
rtl/wsf_div.sv
rtl/wsf_ctrl.sv
rtl/wsf_dp.sv
rtl/whittaker_smoother_first_order.sv
rtl/wsf_check.sv
tb/tb_whittaker_smoother_first_order.sv
